// ----- hdl/kf2s_pkg.sv -----
// Package for the two-state Kalman filter: widths, operand codes, state codes and
// the microcode table that drives the shared multiplier and accumulator.
// No dependencies.
`default_nettype none
package kf2s_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int ACC_W     = DATA_W + 4;
   localparam int MAG_W     = 2 * DATA_W - FRAC_W;
   localparam int DIV_CNT_W = $clog2(MAG_W);
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 64;

   // Last microcode step, and the step that leaves S behind.
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(40);
   localparam logic [STEP_W-1:0] S_STEP    = STEP_W'(25);
   localparam logic [STEP_W-1:0] POST_DIV  = STEP_W'(26);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROW0  = 4'd0,
      CSR_A_ROW1  = 4'd1,
      CSR_H_ROW   = 4'd2,
      CSR_Q_ROW0  = 4'd3,
      CSR_Q_ROW1  = 4'd4,
      CSR_NOISE_R = 4'd5,
      CSR_P_ROW0  = 4'd6,
      CSR_P_ROW1  = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_DIV_LOAD, ST_DIV_RUN, ST_DONE
   } state_type;

   typedef enum logic [5:0] {
      OPD_ZERO, OPD_ONE,
      OPD_A00, OPD_A01, OPD_A10, OPD_A11, OPD_H0, OPD_H1,
      OPD_Q00, OPD_Q01, OPD_Q10, OPD_Q11, OPD_R,
      OPD_U0, OPD_U1, OPD_Z,
      OPD_X0, OPD_X1, OPD_P00, OPD_P01, OPD_P10, OPD_P11,
      OPD_XP0, OPD_XP1, OPD_C0, OPD_C1,
      OPD_PP00, OPD_PP01, OPD_PP10, OPD_PP11,
      OPD_HP0, OPD_HP1, OPD_S, OPD_K0, OPD_K1,
      OPD_HX, OPD_Y, OPD_T0, OPD_T1, OPD_KH01, OPD_KH10
   } opnd_type;

   // One term: acc = (first ? addend : acc) +/- fmul(sa, sb); on last, dst = sat(acc).
   typedef struct packed {
      opnd_type sa;
      opnd_type sb;
      opnd_type add;
      logic     neg;
      logic     first;
      logic     last;
      opnd_type dst;
   } uop_type;

   function automatic uop_type mk(opnd_type sa, opnd_type sb, opnd_type add, logic neg,
                                  logic first, logic last, opnd_type dst);
      uop_type u;
      u.sa = sa; u.sb = sb; u.add = add; u.neg = neg;
      u.first = first; u.last = last; u.dst = dst;
      return u;
   endfunction

   function automatic uop_type uop_at(logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         // predicted state
         6'd0:  u = mk(OPD_A00, OPD_X0, OPD_U0, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd1:  u = mk(OPD_A01, OPD_X1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_XP0);
         6'd2:  u = mk(OPD_A10, OPD_X0, OPD_U1, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd3:  u = mk(OPD_A11, OPD_X1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_XP1);
         // predicted covariance, column 0
         6'd4:  u = mk(OPD_A00, OPD_P00, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd5:  u = mk(OPD_A01, OPD_P10, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_C0);
         6'd6:  u = mk(OPD_A00, OPD_P01, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd7:  u = mk(OPD_A01, OPD_P11, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_C1);
         6'd8:  u = mk(OPD_A00, OPD_C0, OPD_Q00, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd9:  u = mk(OPD_A01, OPD_C1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_PP00);
         6'd10: u = mk(OPD_A10, OPD_C0, OPD_Q10, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd11: u = mk(OPD_A11, OPD_C1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_PP10);
         // column 1
         6'd12: u = mk(OPD_A10, OPD_P00, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd13: u = mk(OPD_A11, OPD_P10, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_C0);
         6'd14: u = mk(OPD_A10, OPD_P01, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd15: u = mk(OPD_A11, OPD_P11, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_C1);
         6'd16: u = mk(OPD_A00, OPD_C0, OPD_Q01, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd17: u = mk(OPD_A01, OPD_C1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_PP01);
         6'd18: u = mk(OPD_A10, OPD_C0, OPD_Q11, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd19: u = mk(OPD_A11, OPD_C1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_PP11);
         // H*P and S
         6'd20: u = mk(OPD_H0, OPD_PP00, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd21: u = mk(OPD_H1, OPD_PP10, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_HP0);
         6'd22: u = mk(OPD_H0, OPD_PP01, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd23: u = mk(OPD_H1, OPD_PP11, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_HP1);
         6'd24: u = mk(OPD_H0, OPD_HP0, OPD_R, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd25: u = mk(OPD_H1, OPD_HP1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_S);
         // innovation; multiplying by one passes the saturated H*x through exactly
         6'd26: u = mk(OPD_H0, OPD_XP0, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd27: u = mk(OPD_H1, OPD_XP1, OPD_ZERO, 1'b0, 1'b0, 1'b1, OPD_HX);
         6'd28: u = mk(OPD_HX, OPD_ONE, OPD_Z, 1'b1, 1'b1, 1'b1, OPD_Y);
         // state update
         6'd29: u = mk(OPD_K0, OPD_Y, OPD_XP0, 1'b0, 1'b1, 1'b1, OPD_X0);
         6'd30: u = mk(OPD_K1, OPD_Y, OPD_XP1, 1'b0, 1'b1, 1'b1, OPD_X1);
         // I - K*H
         6'd31: u = mk(OPD_K0, OPD_H0, OPD_ONE, 1'b1, 1'b1, 1'b1, OPD_T0);
         6'd32: u = mk(OPD_K0, OPD_H1, OPD_ZERO, 1'b0, 1'b1, 1'b1, OPD_KH01);
         6'd33: u = mk(OPD_K1, OPD_H0, OPD_ZERO, 1'b0, 1'b1, 1'b1, OPD_KH10);
         6'd34: u = mk(OPD_K1, OPD_H1, OPD_ONE, 1'b1, 1'b1, 1'b1, OPD_T1);
         // covariance update, the off-diagonal written to both halves
         6'd35: u = mk(OPD_T0, OPD_PP00, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd36: u = mk(OPD_KH01, OPD_PP10, OPD_ZERO, 1'b1, 1'b0, 1'b1, OPD_P00);
         6'd37: u = mk(OPD_T0, OPD_PP01, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd38: u = mk(OPD_KH01, OPD_PP11, OPD_ZERO, 1'b1, 1'b0, 1'b1, OPD_P01);
         6'd39: u = mk(OPD_T1, OPD_PP11, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
         6'd40: u = mk(OPD_KH10, OPD_PP01, OPD_ZERO, 1'b1, 1'b0, 1'b1, OPD_P11);
         default: u = mk(OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 1'b1, 1'b0, OPD_ZERO);
      endcase
      return u;
   endfunction

   function automatic data_type sat_acc(acc_type v);
      acc_type hi;
      acc_type lo;
      hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = -hi - acc_type'(1);
      if (v > hi) return {1'b0, {(DATA_W-1){1'b1}}};
      if (v < lo) return {1'b1, {(DATA_W-1){1'b0}}};
      return v[DATA_W-1:0];
   endfunction

   // Saturate a magnitude with a sign to the data width.
   function automatic data_type sat_mag(logic [MAG_W-1:0] m, logic neg);
      logic [MAG_W-1:0] half_range;
      logic [MAG_W-1:0] neg_m;
      half_range = MAG_W'(1) << (DATA_W - 1);
      neg_m = MAG_W'(0) - m;
      if (neg) begin
         if (m > half_range) return {1'b1, {(DATA_W-1){1'b0}}};
         return neg_m[DATA_W-1:0];
      end
      if (m > half_range - MAG_W'(1)) return {1'b0, {(DATA_W-1){1'b1}}};
      return m[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mag(data_type v);
      return v[DATA_W-1] ? DATA_W'(0) - v : v;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/kf2s_if.sv -----
// Handshake channels of the Kalman filter: request, response and register write.
// Depends on kf2s_pkg.
`default_nettype none
interface kf2s_req_if;
   logic                     valid;
   logic                     ready;
   logic                     action;
   kf2s_pkg::data_type       sample_value;
   kf2s_pkg::data_type       control_0;
   kf2s_pkg::data_type       control_1;
   modport source (output valid, action, sample_value, control_0, control_1, input ready);
   modport sink   (input valid, action, sample_value, control_0, control_1, output ready);
endinterface

interface kf2s_rsp_if;
   logic                     valid;
   logic                     ready;
   kf2s_pkg::data_type       estimate_0;
   kf2s_pkg::data_type       estimate_1;
   logic                     status;
   modport source (output valid, estimate_0, estimate_1, status, input ready);
   modport sink   (input valid, estimate_0, estimate_1, status, output ready);
endinterface

interface kf2s_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kf2s_pkg::CSR_IDX_W-1:0]      index;
   logic [kf2s_pkg::CSR_DAT_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/kalman_filter_two_state.sv -----
// Two-state Kalman filter with a scalar measurement, Q16.16 fixed point.
// Depends on kf2s_pkg and the channel interfaces in kf2s_if.sv.
//
// Use: words arrive on req (action 1 loads the state and the initial covariance,
// action 0 runs one predict/update step with measurement z and control Bu).
// Each word gives one word on rsp with both estimates and a status bit, set when
// the innovation variance S is zero and the state was left as it was.
// The user writes registers through csr only while the block is idle; the block
// does not enforce this. csr is always ready; writes to unused indexes are dropped.
// An init word goes straight to its response. An update word runs 41
// multiply-accumulate terms on one shared 32x32 multiplier, each a multiply then an
// accumulate step, plus two gain divisions on a restoring divider, each after a load
// step; when S is zero the divisions and later terms are skipped. One word is in
// flight at a time; req is ready only while the sequencer is idle.
// The response sits in an output register; if rsp is stalled the next request is
// still taken, and a finished result waits until the previous word has gone.
// Reset (synchronous, active high) restores the register defaults and clears
// the state and covariance to zero.
`default_nettype none
module kalman_filter_two_state (
   input  wire logic        clock,
   input  wire logic        reset,
   kf2s_req_if.sink         req,
   kf2s_rsp_if.source       rsp,
   kf2s_csr_if.sink         csr
);

   localparam int DW = kf2s_pkg::DATA_W;
   localparam int FW = kf2s_pkg::FRAC_W;
   localparam int MW = kf2s_pkg::MAG_W;

   logic [kf2s_pkg::CSR_DAT_W-1:0] a_row0_ff, a_row1_ff, h_row_ff, q_row0_ff, q_row1_ff;
   logic [kf2s_pkg::CSR_DAT_W-1:0] p_row0_ff, p_row1_ff;
   kf2s_pkg::data_type             noise_r_ff;

   kf2s_pkg::data_type x0_ff, x1_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   kf2s_pkg::data_type z_ff, u0_ff, u1_ff;
   kf2s_pkg::data_type xp0_ff, xp1_ff, c0_ff, c1_ff;
   kf2s_pkg::data_type pp00_ff, pp01_ff, pp10_ff, pp11_ff, hp0_ff, hp1_ff, s_ff;
   kf2s_pkg::data_type k0_ff, k1_ff, hx_ff, y_ff, t0_ff, t1_ff, kh01_ff, kh10_ff;
   kf2s_pkg::data_type prod_ff;
   kf2s_pkg::acc_type  acc_ff;

   kf2s_pkg::state_type          state_ff, state_in;
   logic [kf2s_pkg::STEP_W-1:0]  step_ff;
   logic                         status_ff;
   logic                         rsp_valid_ff;
   kf2s_pkg::data_type           est0_ff, est1_ff;
   logic                         rsp_status_ff;

   logic [MW-1:0]                  div_num_ff;
   logic [DW-1:0]                  div_rem_ff;
   logic [DW-1:0]                  div_den_ff;
   logic                           div_neg_ff;
   logic                           div_sel_ff;
   logic [kf2s_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   kf2s_pkg::uop_type  uop;
   kf2s_pkg::data_type opa, opb, addend;
   logic [2*DW-1:0]    prod_full;
   kf2s_pkg::data_type prod_sat;
   kf2s_pkg::acc_type  acc_sum;
   kf2s_pkg::data_type acc_sat;
   logic [DW:0]        rem_try;
   logic               rem_ge;
   logic [DW:0]        rem_diff;
   logic [MW-1:0]      num_next;
   logic               div_last;
   logic               rsp_load;
   logic               req_fire;

   function automatic kf2s_pkg::data_type pick(kf2s_pkg::opnd_type sel);
      kf2s_pkg::data_type v;
      unique case (sel)
         kf2s_pkg::OPD_ZERO: v = '0;
         kf2s_pkg::OPD_ONE:  v = kf2s_pkg::data_type'(1) <<< FW;
         kf2s_pkg::OPD_A00:  v = a_row0_ff[31:0];
         kf2s_pkg::OPD_A01:  v = a_row0_ff[63:32];
         kf2s_pkg::OPD_A10:  v = a_row1_ff[31:0];
         kf2s_pkg::OPD_A11:  v = a_row1_ff[63:32];
         kf2s_pkg::OPD_H0:   v = h_row_ff[31:0];
         kf2s_pkg::OPD_H1:   v = h_row_ff[63:32];
         kf2s_pkg::OPD_Q00:  v = q_row0_ff[31:0];
         kf2s_pkg::OPD_Q01:  v = q_row0_ff[63:32];
         kf2s_pkg::OPD_Q10:  v = q_row1_ff[31:0];
         kf2s_pkg::OPD_Q11:  v = q_row1_ff[63:32];
         kf2s_pkg::OPD_R:    v = noise_r_ff;
         kf2s_pkg::OPD_U0:   v = u0_ff;
         kf2s_pkg::OPD_U1:   v = u1_ff;
         kf2s_pkg::OPD_Z:    v = z_ff;
         kf2s_pkg::OPD_X0:   v = x0_ff;
         kf2s_pkg::OPD_X1:   v = x1_ff;
         kf2s_pkg::OPD_P00:  v = p00_ff;
         kf2s_pkg::OPD_P01:  v = p01_ff;
         kf2s_pkg::OPD_P10:  v = p10_ff;
         kf2s_pkg::OPD_P11:  v = p11_ff;
         kf2s_pkg::OPD_XP0:  v = xp0_ff;
         kf2s_pkg::OPD_XP1:  v = xp1_ff;
         kf2s_pkg::OPD_C0:   v = c0_ff;
         kf2s_pkg::OPD_C1:   v = c1_ff;
         kf2s_pkg::OPD_PP00: v = pp00_ff;
         kf2s_pkg::OPD_PP01: v = pp01_ff;
         kf2s_pkg::OPD_PP10: v = pp10_ff;
         kf2s_pkg::OPD_PP11: v = pp11_ff;
         kf2s_pkg::OPD_HP0:  v = hp0_ff;
         kf2s_pkg::OPD_HP1:  v = hp1_ff;
         kf2s_pkg::OPD_S:    v = s_ff;
         kf2s_pkg::OPD_K0:   v = k0_ff;
         kf2s_pkg::OPD_K1:   v = k1_ff;
         kf2s_pkg::OPD_HX:   v = hx_ff;
         kf2s_pkg::OPD_Y:    v = y_ff;
         kf2s_pkg::OPD_T0:   v = t0_ff;
         kf2s_pkg::OPD_T1:   v = t1_ff;
         kf2s_pkg::OPD_KH01: v = kh01_ff;
         kf2s_pkg::OPD_KH10: v = kh10_ff;
         default:            v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      uop    = kf2s_pkg::uop_at(step_ff);
      opa    = pick(uop.sa);
      opb    = pick(uop.sb);
      addend = pick(uop.add);
   end

   // Shared multiplier: magnitudes, truncated shift, saturation.
   always_comb begin
      prod_full = {{DW{1'b0}}, kf2s_pkg::mag(opa)} * {{DW{1'b0}}, kf2s_pkg::mag(opb)};
      prod_sat  = kf2s_pkg::sat_mag(prod_full[2*DW-1:FW], opa[DW-1] ^ opb[DW-1]);
   end

   always_comb begin
      kf2s_pkg::acc_type base;
      kf2s_pkg::acc_type term;
      base    = uop.first ? kf2s_pkg::acc_type'(addend) : acc_ff;
      term    = kf2s_pkg::acc_type'(prod_ff);
      acc_sum = uop.neg ? base - term : base + term;
      acc_sat = kf2s_pkg::sat_acc(acc_sum);
   end

   // Restoring divider, one quotient bit a cycle.
   always_comb begin
      rem_try  = {div_rem_ff, div_num_ff[MW-1]};
      rem_ge   = rem_try >= {1'b0, div_den_ff};
      rem_diff = rem_ge ? rem_try - {1'b0, div_den_ff} : rem_try;
      num_next = {div_num_ff[MW-2:0], rem_ge};
      div_last = div_cnt_ff == kf2s_pkg::DIV_CNT_W'(MW - 1);
   end

   assign req_fire  = req.valid && req.ready;
   assign req.ready = state_ff == kf2s_pkg::ST_IDLE;
   assign rsp_load  = (state_ff == kf2s_pkg::ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign csr.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kf2s_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = req.action ? kf2s_pkg::ST_DONE : kf2s_pkg::ST_MUL;
            end
         end
         kf2s_pkg::ST_MUL: state_in = kf2s_pkg::ST_ACC;
         kf2s_pkg::ST_ACC: begin
            if (step_ff == kf2s_pkg::S_STEP) begin
               state_in = (acc_sat == '0) ? kf2s_pkg::ST_DONE : kf2s_pkg::ST_DIV_LOAD;
            end else if (step_ff == kf2s_pkg::LAST_STEP) begin
               state_in = kf2s_pkg::ST_DONE;
            end else begin
               state_in = kf2s_pkg::ST_MUL;
            end
         end
         kf2s_pkg::ST_DIV_LOAD: state_in = kf2s_pkg::ST_DIV_RUN;
         kf2s_pkg::ST_DIV_RUN: begin
            if (div_last) begin
               state_in = div_sel_ff ? kf2s_pkg::ST_MUL : kf2s_pkg::ST_DIV_LOAD;
            end
         end
         kf2s_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = kf2s_pkg::ST_IDLE;
            end
         end
         default: state_in = kf2s_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kf2s_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_row0_ff  <= 64'd65536;
         a_row1_ff  <= 64'd281474976710656;
         h_row_ff   <= 64'd65536;
         q_row0_ff  <= '0;
         q_row1_ff  <= '0;
         noise_r_ff <= 32'sd65536;
         p_row0_ff  <= 64'd65536;
         p_row1_ff  <= 64'd281474976710656;
      end else if (csr.valid) begin
         case (csr.index)
            kf2s_pkg::CSR_A_ROW0:  a_row0_ff  <= csr.data;
            kf2s_pkg::CSR_A_ROW1:  a_row1_ff  <= csr.data;
            kf2s_pkg::CSR_H_ROW:   h_row_ff   <= csr.data;
            kf2s_pkg::CSR_Q_ROW0:  q_row0_ff  <= csr.data;
            kf2s_pkg::CSR_Q_ROW1:  q_row1_ff  <= csr.data;
            kf2s_pkg::CSR_NOISE_R: noise_r_ff <= csr.data[DW-1:0];
            kf2s_pkg::CSR_P_ROW0:  p_row0_ff  <= csr.data;
            kf2s_pkg::CSR_P_ROW1:  p_row1_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // Filter state and sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff      <= '0;
         x1_ff      <= '0;
         p00_ff     <= '0;
         p01_ff     <= '0;
         p10_ff     <= '0;
         p11_ff     <= '0;
         step_ff    <= '0;
         status_ff  <= 1'b0;
         div_sel_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            kf2s_pkg::ST_IDLE: begin
               step_ff    <= '0;
               status_ff  <= 1'b0;
               div_sel_ff <= 1'b0;
               if (req_fire) begin
                  z_ff  <= req.sample_value;
                  u0_ff <= req.control_0;
                  u1_ff <= req.control_1;
                  if (req.action) begin
                     x0_ff  <= req.sample_value;
                     x1_ff  <= '0;
                     p00_ff <= p_row0_ff[31:0];
                     p01_ff <= p_row0_ff[63:32];
                     p10_ff <= p_row1_ff[31:0];
                     p11_ff <= p_row1_ff[63:32];
                  end
               end
            end
            kf2s_pkg::ST_MUL: prod_ff <= prod_sat;
            kf2s_pkg::ST_ACC: begin
               acc_ff  <= acc_sum;
               step_ff <= step_ff + kf2s_pkg::STEP_W'(1);
               if ((step_ff == kf2s_pkg::S_STEP) && (acc_sat == '0)) begin
                  status_ff <= 1'b1;
               end
               if (uop.last) begin
                  case (uop.dst)
                     kf2s_pkg::OPD_XP0:  xp0_ff  <= acc_sat;
                     kf2s_pkg::OPD_XP1:  xp1_ff  <= acc_sat;
                     kf2s_pkg::OPD_C0:   c0_ff   <= acc_sat;
                     kf2s_pkg::OPD_C1:   c1_ff   <= acc_sat;
                     kf2s_pkg::OPD_PP00: pp00_ff <= acc_sat;
                     kf2s_pkg::OPD_PP01: pp01_ff <= acc_sat;
                     kf2s_pkg::OPD_PP10: pp10_ff <= acc_sat;
                     kf2s_pkg::OPD_PP11: pp11_ff <= acc_sat;
                     kf2s_pkg::OPD_HP0:  hp0_ff  <= acc_sat;
                     kf2s_pkg::OPD_HP1:  hp1_ff  <= acc_sat;
                     kf2s_pkg::OPD_S:    s_ff    <= acc_sat;
                     kf2s_pkg::OPD_HX:   hx_ff   <= acc_sat;
                     kf2s_pkg::OPD_Y:    y_ff    <= acc_sat;
                     kf2s_pkg::OPD_X0:   x0_ff   <= acc_sat;
                     kf2s_pkg::OPD_X1:   x1_ff   <= acc_sat;
                     kf2s_pkg::OPD_T0:   t0_ff   <= acc_sat;
                     kf2s_pkg::OPD_T1:   t1_ff   <= acc_sat;
                     kf2s_pkg::OPD_KH01: kh01_ff <= acc_sat;
                     kf2s_pkg::OPD_KH10: kh10_ff <= acc_sat;
                     kf2s_pkg::OPD_P00:  p00_ff  <= acc_sat;
                     kf2s_pkg::OPD_P01: begin
                        p01_ff <= acc_sat;
                        p10_ff <= acc_sat;
                     end
                     kf2s_pkg::OPD_P11:  p11_ff  <= acc_sat;
                     default: ;
                  endcase
               end
            end
            kf2s_pkg::ST_DIV_LOAD: begin
               div_num_ff <= {{(MW-DW){1'b0}},
                              kf2s_pkg::mag(div_sel_ff ? hp1_ff : hp0_ff)} << FW;
               div_rem_ff <= '0;
               div_den_ff <= kf2s_pkg::mag(s_ff);
               div_neg_ff <= (div_sel_ff ? hp1_ff[DW-1] : hp0_ff[DW-1]) ^ s_ff[DW-1];
               div_cnt_ff <= '0;
            end
            kf2s_pkg::ST_DIV_RUN: begin
               div_num_ff <= num_next;
               div_rem_ff <= rem_diff[DW-1:0];
               div_cnt_ff <= div_cnt_ff + kf2s_pkg::DIV_CNT_W'(1);
               if (div_last) begin
                  if (div_sel_ff) begin
                     k1_ff <= kf2s_pkg::sat_mag(num_next, div_neg_ff);
                  end else begin
                     k0_ff <= kf2s_pkg::sat_mag(num_next, div_neg_ff);
                  end
                  div_sel_ff <= 1'b1;
                  step_ff    <= kf2s_pkg::POST_DIV;
               end
            end
            kf2s_pkg::ST_DONE: ;
            default: ;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         est0_ff       <= x0_ff;
         est1_ff       <= x1_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.estimate_0 = est0_ff;
   assign rsp.estimate_1 = est1_ff;
   assign rsp.status     = rsp_status_ff;

   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req.action) |=> (state_ff == kf2s_pkg::ST_MUL) && (step_ff == '0))
      else $error("update word did not start the microcode at its first term");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kf2s_pkg::ST_MUL) |-> (step_ff <= kf2s_pkg::LAST_STEP))
      else $error("microcode step ran past the last term");

   a_resp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == kf2s_pkg::ST_DONE))
      else $error("response raised outside the completion state");

   a_zero_s_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kf2s_pkg::ST_DIV_LOAD) |-> (s_ff != '0) && !status_ff)
      else $error("gain division started with a zero innovation variance");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the two-state Kalman filter: directed cases, then random words.
// Depends on kf2s_pkg, the channel interfaces in kf2s_if.sv and the filter itself.
`timescale 1ns / 1ps
module tb_top;

   localparam longint MAX_CYCLES = 64'd4000000;

   typedef struct {
      logic               action;
      kf2s_pkg::data_type sample_value;
      kf2s_pkg::data_type control_0;
      kf2s_pkg::data_type control_1;
   } req_word_type;

   typedef struct {
      kf2s_pkg::data_type estimate_0;
      kf2s_pkg::data_type estimate_1;
      logic               status;
   } rsp_word_type;

   typedef struct {
      req_word_type w;
      logic         typed;
      rsp_word_type r;
   } table_row_type;

   logic clock;
   logic reset;
   kf2s_req_if req ();
   kf2s_rsp_if rsp ();
   kf2s_csr_if csr ();

   kalman_filter_two_state dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));

   // Predictor copy of the registers and filter state.
   logic [63:0] m_a0, m_a1, m_h, m_q0, m_q1, m_p0, m_p1;
   logic [31:0] m_r;
   longint      m_x[2];
   longint      m_p[4];

   rsp_word_type estimates_due[$];
   int          failures;
   int          table_failures;
   int          responses_seen;
   longint      cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          n_errors_seen;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clip(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint lane(logic [63:0] reg_val, bit hi);
      logic signed [31:0] w;
      w = hi ? reg_val[63:32] : reg_val[31:0];
      return longint'(w);
   endfunction

   // Fixed-point product: exact, truncated toward zero, saturated.
   function automatic longint qmul(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0] m;
      bit neg;
      p = 128'(signed'(a)) * 128'(signed'(b));
      neg = p[127];
      m = neg ? -p : p;
      m = m >> kf2s_pkg::FRAC_W;
      if (neg) return (m > 128'(VMAX) + 1) ? VMIN : -longint'(m);
      return (m > 128'(VMAX)) ? VMAX : longint'(m);
   endfunction

   function automatic longint qdiv(longint n, longint d);
      logic [127:0] un, ud, q;
      bit neg;
      un = (n < 0) ? 128'(-n) : 128'(n);
      ud = (d < 0) ? 128'(-d) : 128'(d);
      q = (un << kf2s_pkg::FRAC_W) / ud;
      neg = (n < 0) != (d < 0);
      if (neg) return (q > 128'(VMAX) + 1) ? VMIN : -longint'(q);
      return (q > 128'(VMAX)) ? VMAX : longint'(q);
   endfunction

   function automatic rsp_word_type kalman_step(req_word_type w);
      rsp_word_type o;
      longint a[2][2], q[2][2], h0, h1, r, xp[2], pp[2][2], hp[2], s, k[2], y;
      longint kh00, kh01, kh10, kh11, c0, c1;
      o.status = 1'b0;
      if (w.action) begin
         m_x[0] = longint'(w.sample_value);
         m_x[1] = 0;
         m_p[0] = lane(m_p0, 0); m_p[1] = lane(m_p0, 1);
         m_p[2] = lane(m_p1, 0); m_p[3] = lane(m_p1, 1);
      end else begin
         a[0][0] = lane(m_a0, 0); a[0][1] = lane(m_a0, 1);
         a[1][0] = lane(m_a1, 0); a[1][1] = lane(m_a1, 1);
         q[0][0] = lane(m_q0, 0); q[0][1] = lane(m_q0, 1);
         q[1][0] = lane(m_q1, 0); q[1][1] = lane(m_q1, 1);
         h0 = lane(m_h, 0); h1 = lane(m_h, 1);
         r = longint'(signed'(m_r));
         xp[0] = clip(qmul(a[0][0], m_x[0]) + qmul(a[0][1], m_x[1]) + w.control_0);
         xp[1] = clip(qmul(a[1][0], m_x[0]) + qmul(a[1][1], m_x[1]) + w.control_1);
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               c0 = clip(qmul(a[j][0], m_p[0]) + qmul(a[j][1], m_p[2]));
               c1 = clip(qmul(a[j][0], m_p[1]) + qmul(a[j][1], m_p[3]));
               pp[i][j] = clip(qmul(a[i][0], c0) + qmul(a[i][1], c1) + q[i][j]);
            end
         hp[0] = clip(qmul(h0, pp[0][0]) + qmul(h1, pp[1][0]));
         hp[1] = clip(qmul(h0, pp[0][1]) + qmul(h1, pp[1][1]));
         s = clip(qmul(h0, hp[0]) + qmul(h1, hp[1]) + r);
         if (s == 0) begin
            o.status = 1'b1;
         end else begin
            k[0] = qdiv(hp[0], s);
            k[1] = qdiv(hp[1], s);
            y = clip(longint'(w.sample_value) - clip(qmul(h0, xp[0]) + qmul(h1, xp[1])));
            m_x[0] = clip(xp[0] + qmul(k[0], y));
            m_x[1] = clip(xp[1] + qmul(k[1], y));
            kh00 = qmul(k[0], h0); kh01 = qmul(k[0], h1);
            kh10 = qmul(k[1], h0); kh11 = qmul(k[1], h1);
            m_p[0] = clip(qmul(clip(65536 - kh00), pp[0][0]) - qmul(kh01, pp[1][0]));
            m_p[1] = clip(qmul(clip(65536 - kh00), pp[0][1]) - qmul(kh01, pp[1][1]));
            m_p[2] = m_p[1];
            m_p[3] = clip(qmul(clip(65536 - kh11), pp[1][1]) - qmul(kh10, pp[0][1]));
         end
      end
      o.estimate_0 = kf2s_pkg::data_type'(m_x[0]);
      o.estimate_1 = kf2s_pkg::data_type'(m_x[1]);
      return o;
   endfunction

   // Cycle limit and the response checker.
   always @(posedge clock) begin
      rsp_word_type want;
      int bad;
      bad = 0;
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset) begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp.valid && rsp.ready) begin
            responses_seen <= responses_seen + 1;
            if (estimates_due.size() == 0) begin
               $error("response word with nothing expected");
               bad++;
            end else begin
               want = estimates_due.pop_front();
               if (rsp.status) n_errors_seen <= n_errors_seen + 1;
               if (rsp.estimate_0 !== want.estimate_0) begin
                  $error("estimate_0 expected %0d got %0d", want.estimate_0, rsp.estimate_0);
                  bad++;
               end
               if (rsp.estimate_1 !== want.estimate_1) begin
                  $error("estimate_1 expected %0d got %0d", want.estimate_1, rsp.estimate_1);
                  bad++;
               end
               if (rsp.status !== want.status) begin
                  $error("status expected %0b got %0b", want.status, rsp.status);
                  bad++;
               end
            end
            if (bad != 0) failures <= failures + bad;
         end
      end
   end

   task automatic write_reg(kf2s_pkg::csr_index_type idx, logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         kf2s_pkg::CSR_A_ROW0:  m_a0 = value;
         kf2s_pkg::CSR_A_ROW1:  m_a1 = value;
         kf2s_pkg::CSR_H_ROW:   m_h = value;
         kf2s_pkg::CSR_Q_ROW0:  m_q0 = value;
         kf2s_pkg::CSR_Q_ROW1:  m_q1 = value;
         kf2s_pkg::CSR_NOISE_R: m_r = value[31:0];
         kf2s_pkg::CSR_P_ROW0:  m_p0 = value;
         kf2s_pkg::CSR_P_ROW1:  m_p1 = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Sends one word; queues the directed response, else the predicted one, on accept.
   task automatic send_word(req_word_type w, bit typed, rsp_word_type typed_rsp);
      rsp_word_type p;
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req.valid        <= 1'b1;
      req.action       <= w.action;
      req.sample_value <= w.sample_value;
      req.control_0    <= w.control_0;
      req.control_1    <= w.control_1;
      do @(posedge clock); while (!req.ready);
      p = kalman_step(w);
      if (typed && ((p.estimate_0 != typed_rsp.estimate_0) ||
                    (p.estimate_1 != typed_rsp.estimate_1) ||
                    (p.status != typed_rsp.status))) begin
         $error("directed row disagrees with predictor");
         table_failures = table_failures + 1;
      end
      estimates_due.push_back(typed ? typed_rsp : p);
      req.valid <= 1'b0;
      // The block is never ready on the cycle after an accept, so no time is lost.
      @(posedge clock);
   endtask

   task automatic drain();
      while (estimates_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic kf2s_pkg::data_type rnd_q(int mode);
      case (mode)
         0: return kf2s_pkg::data_type'($urandom);
         1: return kf2s_pkg::data_type'($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
         default: return kf2s_pkg::data_type'($urandom_range(32'h0000_4000)) - 32'sh0000_2000;
      endcase
   endfunction

   function automatic logic [63:0] rnd_pair(int mode);
      return {rnd_q(mode), rnd_q(mode)};
   endfunction

   task automatic random_config(int mode);
      write_reg(kf2s_pkg::CSR_A_ROW0,
                mode == 2 ? {32'sh0000_0800, 32'sh0001_0000} : rnd_pair(mode));
      write_reg(kf2s_pkg::CSR_A_ROW1,
                mode == 2 ? {32'sh0000_F000, 32'sh0000_0000} : rnd_pair(mode));
      write_reg(kf2s_pkg::CSR_H_ROW, rnd_pair(mode == 0 ? 0 : 1));
      write_reg(kf2s_pkg::CSR_Q_ROW0, rnd_pair(mode));
      write_reg(kf2s_pkg::CSR_Q_ROW1, rnd_pair(mode));
      write_reg(kf2s_pkg::CSR_NOISE_R, {$urandom, rnd_q(mode)});
      write_reg(kf2s_pkg::CSR_P_ROW0, rnd_pair(mode));
      write_reg(kf2s_pkg::CSR_P_ROW1, rnd_pair(mode));
   endtask

   initial begin
      table_row_type rows[$];
      req_word_type  w;
      rsp_word_type  none;
      int            sent;
      int            phase;
      int            mode;

      reset = 1'b1;
      cycle_count = 0;
      failures = 0;
      table_failures = 0;
      responses_seen = 0;
      n_errors_seen = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req.valid = 1'b0; req.action = 1'b0;
      req.sample_value = '0; req.control_0 = '0; req.control_1 = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      m_a0 = 64'd65536; m_a1 = 64'd281474976710656; m_h = 64'd65536;
      m_q0 = '0; m_q1 = '0; m_r = 32'd65536;
      m_p0 = 64'd65536; m_p1 = 64'd281474976710656;
      m_x[0] = 0; m_x[1] = 0;
      for (int i = 0; i < 4; i++) m_p[i] = 0;
      none = '{default: '0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. With reset registers and zero covariance S equals R, so an
      // update from reset leaves the state at the control terms.
      rows.push_back('{'{1'b0, 32'sd0, 32'sd5, -32'sd7}, 1'b1, '{32'sd5, -32'sd7, 1'b0}});
      rows.push_back('{'{1'b1, 32'h7FFF_FFFF, -32'sd1, 32'sd1}, 1'b1,
                       '{32'h7FFF_FFFF, 32'sd0, 1'b0}});
      rows.push_back('{'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
                       '{32'h8000_0000, 32'sd0, 1'b0}});
      rows.push_back('{'{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, none});
      rows.push_back('{'{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, none});
      rows.push_back('{'{1'b1, 32'sh0002_0000, 32'sd0, 32'sd0}, 1'b1,
                       '{32'sh0002_0000, 32'sd0, 1'b0}});
      rows.push_back('{'{1'b0, 32'sh0003_0000, 32'sd0, 32'sd0}, 1'b0, none});
      rows.push_back('{'{1'b0, -32'sh0001_0000, 32'sh0000_1000, -32'sh0000_1000}, 1'b0, none});
      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
      drain();

      // Zero innovation variance: H and R zero, so every update reports status.
      write_reg(kf2s_pkg::CSR_H_ROW, 64'd0);
      write_reg(kf2s_pkg::CSR_NOISE_R, 64'd0);
      send_word('{1'b1, 32'sh0001_0000, 32'sd0, 32'sd0}, 1'b1,
                '{32'sh0001_0000, 32'sd0, 1'b0});
      send_word('{1'b0, 32'sh0005_0000, 32'sd9, 32'sd9}, 1'b1,
                '{32'sh0001_0000, 32'sd0, 1'b1});
      drain();
      // Extreme register values.
      write_reg(kf2s_pkg::CSR_A_ROW0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(kf2s_pkg::CSR_A_ROW1, 64'h7FFF_FFFF_8000_0000);
      write_reg(kf2s_pkg::CSR_H_ROW, 64'h8000_0000_7FFF_FFFF);
      write_reg(kf2s_pkg::CSR_Q_ROW0, 64'h7FFF_FFFF_7FFF_FFFF);
      write_reg(kf2s_pkg::CSR_Q_ROW1, 64'h8000_0000_8000_0000);
      write_reg(kf2s_pkg::CSR_NOISE_R, 64'h0000_0000_8000_0000);
      write_reg(kf2s_pkg::CSR_P_ROW0, 64'h8000_0000_7FFF_FFFF);
      write_reg(kf2s_pkg::CSR_P_ROW1, 64'h7FFF_FFFF_8000_0000);
      send_word('{1'b1, 32'sh0001_0000, 32'sd0, 32'sd0}, 1'b0, none);
      for (int i = 0; i < 4; i++)
         send_word('{1'b0, kf2s_pkg::data_type'($urandom), kf2s_pkg::data_type'($urandom),
                     kf2s_pkg::data_type'($urandom)}, 1'b0, none);
      drain();

      // Random part: phases with different idling, each with a fresh setting.
      sent = 0;
      phase = 0;
      while (sent < 1550) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
         random_config(mode);
         // Mostly well-formed tracks: an init, then a run of updates.
         for (int n = 0; n < 40; n++) begin
            w.action = (n == 0) || ($urandom_range(15) == 0);
            w.sample_value = $urandom_range(7) == 0 ? kf2s_pkg::data_type'($urandom) : rnd_q(1);
            w.control_0 = $urandom_range(7) == 0 ? kf2s_pkg::data_type'($urandom) : rnd_q(2);
            w.control_1 = $urandom_range(7) == 0 ? kf2s_pkg::data_type'($urandom) : rnd_q(2);
            send_word(w, 1'b0, none);
            sent++;
         end
         drain();
         phase++;
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      $display("Covered %0d response words over %0d register settings and four idling mixes;",
               responses_seen, phase + 3);
      $display("%0d of them reported a zero innovation variance.", n_errors_seen);
      if ((failures == 0) && (table_failures == 0)) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
